### design/pcbc_pkg.sv
// Package: shared types, codes and defaults for the pinned clock block cache.
`default_nettype none
package pcbc_pkg;

    parameter int ID_W         = 31;
    parameter int SLOT_W       = 6;
    parameter int CODE_W       = 4;
    parameter int SLOTS_DEF    = 64;
    parameter int REF_BITS_DEF = 16;
    parameter int PIN_BITS_DEF = 8;

    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_RELEASE = 2'd1,
        OP_FILL    = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [CODE_W-1:0] {
        C_HIT_LOADED  = 4'd0,
        C_HIT_PENDING = 4'd1,
        C_FREE_SLOT   = 4'd2,
        C_EVICTED     = 4'd3,
        C_NO_VICTIM   = 4'd4,
        C_RELEASED    = 4'd5,
        C_REL_ERROR   = 4'd6,
        C_FILLED      = 4'd7,
        C_CLEARED     = 4'd8
    } t_code;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_PENDING = 2'd1,
        ST_LOADED  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT,
        S_SCAN,
        S_DECIDE,
        S_SUB,
        S_WALK,
        S_EMIT
    } t_state;

    // Per-slot decode from the shared slot unit.
    typedef struct packed {
        logic occupied;
        logic is_free;
        logic pending;
        logic loaded;
        logic unpinned;
        logic tag_hit;
        logic ref_le1;
        logic ref_lt_m;
    } t_slot_flags;

endpackage
`default_nettype wire

### design/pcbc_if.sv
// Interfaces: request channel and result channel of the block cache.
`default_nettype none
interface pcbc_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  operation;
    logic [pcbc_pkg::ID_W-1:0]   req_id;
    logic [pcbc_pkg::SLOT_W-1:0] slot;

    modport source (output valid, output operation, output req_id, output slot,
                    input ready);
    modport sink   (input valid, input operation, input req_id, input slot,
                    output ready);
endinterface

interface pcbc_out_if;
    logic                        valid;
    logic                        ready;
    logic [pcbc_pkg::SLOT_W-1:0] result_slot;
    logic [pcbc_pkg::CODE_W-1:0] result_code;
    logic [pcbc_pkg::ID_W-1:0]   evicted_block;
    logic                        evicted_valid;

    modport source (output valid, output result_slot, output result_code,
                    output evicted_block, output evicted_valid, input ready);
    modport sink   (input valid, input result_slot, input result_code,
                    input evicted_block, input evicted_valid, output ready);
endinterface
`default_nettype wire

### design/pinned_clock_block_cache.sv
// Top level: sequencer, slot state memories and result register of the block cache.
//
// Slot manager for a block cache with clock replacement and pin counts.
// i_in carries one command word (operation, req_id, slot); o_out carries
// one result word (result_slot, result_code, evicted_block, evicted_valid)
// for every command. Both use valid/ready; a word moves when both are high.
// One command is worked at a time; i_in.ready is high only while idle.
// Slot state sits in two RAMs (tags, and status/pin/ref words) walked one
// slot per cycle by a single shared slot unit. Steps from accept to result:
//   release / fill done : the addressed slot only
//   request hit         : tag scan from slot 0, up to the hit
//   free slot/no victim : scan, then decide
//   request, eviction   : scan, decay pass, walk
//   clear all           : one word written per cycle
// i_in.ready returns in the same cycle as the result word appears on o_out.
// After reset a clearing pass writes every slot free;
// i_in.ready stays low until it ends and no result word is produced.
// A finished result waits in a holding register; if o_out stalls, the
// sequencer holds in its emit state until the output register frees up.
`default_nettype none
module pinned_clock_block_cache #(
    parameter int SLOTS    = pcbc_pkg::SLOTS_DEF,
    parameter int REF_BITS = pcbc_pkg::REF_BITS_DEF,
    parameter int PIN_BITS = pcbc_pkg::PIN_BITS_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    pcbc_in_if.sink  i_in,
    pcbc_out_if.source o_out
);
    localparam int SW = $clog2(SLOTS);
    localparam int CW = SW + 1;
    localparam int MW = 2 + PIN_BITS + REF_BITS;
    localparam int IW = pcbc_pkg::ID_W;

    pcbc_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_pv, n_pv;
    logic [SW-1:0]    r_pidx, n_pidx;
    logic [SW-1:0]    r_wa, n_wa;
    logic [SW-1:0]    r_hand, n_hand;
    logic [CW-1:0]    r_free, n_free;
    pcbc_pkg::t_op    r_op, n_op;
    logic [IW-1:0]    r_id, n_id;
    logic [pcbc_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic             r_ok, n_ok;
    logic             r_have_ge, n_have_ge, r_have_lt, n_have_lt;
    logic [SW-1:0]    r_ge, n_ge, r_lt, n_lt;
    logic             r_any, n_any;
    logic [REF_BITS-1:0] r_m, n_m, r_k, n_k;
    logic             r_clr_op, n_clr_op;

    // result holding register
    logic [pcbc_pkg::SLOT_W-1:0] r_rs_slot, n_rs_slot;
    pcbc_pkg::t_code             r_rs_code, n_rs_code;
    logic [IW-1:0]               r_rs_ev, n_rs_ev;
    logic                        r_rs_evv, n_rs_evv;

    // output register
    logic                        r_o_valid;
    logic [pcbc_pkg::SLOT_W-1:0] r_o_slot;
    pcbc_pkg::t_code             r_o_code;
    logic [IW-1:0]               r_o_ev;
    logic                        r_o_evv;
    logic                        load_out;

    // memory ports
    logic [SW-1:0]  rd_addr, waddr;
    logic           we, tag_we;
    logic [MW-1:0]  wdata, meta_rd, meta_claim;
    logic [IW-1:0]  tag_rd;

    logic [1:0]          m_status;
    logic [PIN_BITS-1:0] m_pin;
    logic [REF_BITS-1:0] m_ref;
    pcbc_pkg::t_slot_flags fl;
    logic [PIN_BITS-1:0] pin_inc, pin_dec;
    logic [REF_BITS-1:0] ref_inc, ref_sub, ref_dec;
    logic                accept;

    function automatic logic [SW-1:0] f_next(input logic [SW-1:0] p);
        return (p == SW'(SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    assign m_status = meta_rd[MW-1 -: 2];
    assign m_pin    = meta_rd[REF_BITS +: PIN_BITS];
    assign m_ref    = meta_rd[REF_BITS-1:0];
    assign meta_claim = {pcbc_pkg::ST_PENDING, PIN_BITS'(1), REF_BITS'(1)};

    pcbc_ram #(.W(MW), .D(SLOTS)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (meta_rd)
    );

    pcbc_ram #(.W(IW), .D(SLOTS)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (waddr),
        .i_wdata (r_id),
        .i_raddr (rd_addr),
        .o_rdata (tag_rd)
    );

    pcbc_slot_unit #(.PIN_BITS(PIN_BITS), .REF_BITS(REF_BITS)) u_unit (
        .i_status  (m_status),
        .i_pin     (m_pin),
        .i_ref     (m_ref),
        .i_tag     (tag_rd),
        .i_id      (r_id),
        .i_k       (r_k),
        .i_m       (r_m),
        .o_flags   (fl),
        .o_pin_inc (pin_inc),
        .o_pin_dec (pin_dec),
        .o_ref_inc (ref_inc),
        .o_ref_sub (ref_sub),
        .o_ref_dec (ref_dec)
    );

    assign i_in.ready = (r_state == pcbc_pkg::S_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pcbc_pkg::S_CLEAR;
            r_cnt     <= '0;
            r_pv      <= 1'b0;
            r_hand    <= '0;
            r_free    <= CW'(SLOTS);
            r_clr_op  <= 1'b0;
            r_have_ge <= 1'b0;
            r_have_lt <= 1'b0;
            r_any     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_pv      <= n_pv;
            r_hand    <= n_hand;
            r_free    <= n_free;
            r_clr_op  <= n_clr_op;
            r_have_ge <= n_have_ge;
            r_have_lt <= n_have_lt;
            r_any     <= n_any;
        end
        r_pidx    <= n_pidx;
        r_wa      <= n_wa;
        r_op      <= n_op;
        r_id      <= n_id;
        r_slot    <= n_slot;
        r_ok      <= n_ok;
        r_ge      <= n_ge;
        r_lt      <= n_lt;
        r_m       <= n_m;
        r_k       <= n_k;
        r_rs_slot <= n_rs_slot;
        r_rs_code <= n_rs_code;
        r_rs_ev   <= n_rs_ev;
        r_rs_evv  <= n_rs_evv;
    end

    // output register: loads from the holding register, drains on ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
        if (load_out) begin
            r_o_slot <= r_rs_slot;
            r_o_code <= r_rs_code;
            r_o_ev   <= r_rs_ev;
            r_o_evv  <= r_rs_evv;
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.result_slot   = r_o_slot;
    assign o_out.result_code   = r_o_code;
    assign o_out.evicted_block = r_o_ev;
    assign o_out.evicted_valid = r_o_evv;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_pv      = r_pv;
        n_pidx    = r_pidx;
        n_wa      = r_wa;
        n_hand    = r_hand;
        n_free    = r_free;
        n_op      = r_op;
        n_id      = r_id;
        n_slot    = r_slot;
        n_ok      = r_ok;
        n_have_ge = r_have_ge;
        n_have_lt = r_have_lt;
        n_ge      = r_ge;
        n_lt      = r_lt;
        n_any     = r_any;
        n_m       = r_m;
        n_k       = r_k;
        n_clr_op  = r_clr_op;
        n_rs_slot = r_rs_slot;
        n_rs_code = r_rs_code;
        n_rs_ev   = r_rs_ev;
        n_rs_evv  = r_rs_evv;
        rd_addr   = r_cnt[SW-1:0];
        waddr     = r_pidx;
        we        = 1'b0;
        tag_we    = 1'b0;
        wdata     = meta_rd;
        load_out  = 1'b0;

        unique case (r_state)
            pcbc_pkg::S_CLEAR: begin
                // one slot written free per cycle
                we    = 1'b1;
                waddr = r_cnt[SW-1:0];
                wdata = {pcbc_pkg::ST_FREE, PIN_BITS'(0), REF_BITS'(0)};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(SLOTS - 1)) begin
                    n_cnt  = '0;
                    n_hand = '0;
                    n_free = CW'(SLOTS);
                    if (r_clr_op) begin
                        n_clr_op  = 1'b0;
                        n_rs_slot = '0;
                        n_rs_code = pcbc_pkg::C_CLEARED;
                        n_rs_ev   = '0;
                        n_rs_evv  = 1'b0;
                        n_state   = pcbc_pkg::S_EMIT;
                    end else begin
                        n_state = pcbc_pkg::S_IDLE;
                    end
                end
            end
            pcbc_pkg::S_IDLE: begin
                rd_addr = SW'(i_in.slot);
                if (accept) begin
                    n_op      = pcbc_pkg::t_op'(i_in.operation);
                    n_id      = i_in.req_id;
                    n_slot    = i_in.slot;
                    n_ok      = (32'(i_in.slot) < SLOTS);
                    n_cnt     = '0;
                    n_pv      = 1'b0;
                    n_have_ge = 1'b0;
                    n_have_lt = 1'b0;
                    n_any     = 1'b0;
                    unique case (pcbc_pkg::t_op'(i_in.operation))
                        pcbc_pkg::OP_REQUEST: n_state = pcbc_pkg::S_SCAN;
                        pcbc_pkg::OP_RELEASE: n_state = pcbc_pkg::S_SLOT;
                        pcbc_pkg::OP_FILL:    n_state = pcbc_pkg::S_SLOT;
                        pcbc_pkg::OP_CLEAR: begin
                            n_clr_op = 1'b1;
                            n_state  = pcbc_pkg::S_CLEAR;
                        end
                        default: n_state = pcbc_pkg::S_IDLE;
                    endcase
                end
            end
            pcbc_pkg::S_SLOT: begin
                waddr     = SW'(r_slot);
                n_rs_slot = r_slot;
                n_rs_ev   = '0;
                n_rs_evv  = 1'b0;
                n_state   = pcbc_pkg::S_EMIT;
                if (r_op == pcbc_pkg::OP_RELEASE) begin
                    if (r_ok && fl.occupied && !fl.unpinned) begin
                        we        = 1'b1;
                        wdata     = {m_status, pin_dec, m_ref};
                        n_rs_code = pcbc_pkg::C_RELEASED;
                    end else begin
                        n_rs_code = pcbc_pkg::C_REL_ERROR;
                    end
                end else begin
                    if (r_ok && fl.pending) begin
                        we    = 1'b1;
                        wdata = {pcbc_pkg::ST_LOADED, m_pin, m_ref};
                    end
                    n_rs_code = pcbc_pkg::C_FILLED;
                end
            end
            pcbc_pkg::S_SCAN: begin
                // tag match, first free slot from the hand, minimum ref count
                if (r_cnt != CW'(SLOTS)) begin
                    n_cnt  = r_cnt + 1'b1;
                    n_pv   = 1'b1;
                    n_pidx = r_cnt[SW-1:0];
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    if (fl.tag_hit) begin
                        we        = 1'b1;
                        wdata     = {m_status, pin_inc, ref_inc};
                        n_rs_slot = pcbc_pkg::SLOT_W'(r_pidx);
                        n_rs_code = fl.loaded ? pcbc_pkg::C_HIT_LOADED
                                              : pcbc_pkg::C_HIT_PENDING;
                        n_rs_ev   = '0;
                        n_rs_evv  = 1'b0;
                        n_state   = pcbc_pkg::S_EMIT;
                    end else begin
                        if (fl.is_free && r_pidx >= r_hand && !r_have_ge) begin
                            n_have_ge = 1'b1;
                            n_ge      = r_pidx;
                        end
                        if (fl.is_free && r_pidx < r_hand && !r_have_lt) begin
                            n_have_lt = 1'b1;
                            n_lt      = r_pidx;
                        end
                        if (fl.unpinned && (!r_any || fl.ref_lt_m)) begin
                            n_any = 1'b1;
                            n_m   = m_ref;
                        end
                    end
                end else if (r_cnt == CW'(SLOTS)) begin
                    n_state = pcbc_pkg::S_DECIDE;
                end
            end
            pcbc_pkg::S_DECIDE: begin
                n_rs_ev  = '0;
                n_rs_evv = 1'b0;
                if (r_free != '0 && (r_have_ge || r_have_lt)) begin
                    waddr     = r_have_ge ? r_ge : r_lt;
                    we        = 1'b1;
                    tag_we    = 1'b1;
                    wdata     = meta_claim;
                    n_free    = r_free - 1'b1;
                    n_hand    = f_next(waddr);
                    n_rs_slot = pcbc_pkg::SLOT_W'(waddr);
                    n_rs_code = pcbc_pkg::C_FREE_SLOT;
                    n_state   = pcbc_pkg::S_EMIT;
                end else if (!r_any) begin
                    n_rs_slot = '0;
                    n_rs_code = pcbc_pkg::C_NO_VICTIM;
                    n_state   = pcbc_pkg::S_EMIT;
                end else begin
                    // full clock passes collapsed into one decay by m-1
                    n_k     = (r_m == '0) ? '0 : r_m - 1'b1;
                    n_cnt   = '0;
                    n_pv    = 1'b0;
                    n_state = pcbc_pkg::S_SUB;
                end
            end
            pcbc_pkg::S_SUB: begin
                if (r_cnt != CW'(SLOTS)) begin
                    n_cnt  = r_cnt + 1'b1;
                    n_pv   = 1'b1;
                    n_pidx = r_cnt[SW-1:0];
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    if (fl.unpinned) begin
                        we    = 1'b1;
                        wdata = {m_status, m_pin, ref_sub};
                    end
                end else if (r_cnt == CW'(SLOTS)) begin
                    n_cnt   = '0;
                    n_wa    = r_hand;
                    n_state = pcbc_pkg::S_WALK;
                end
            end
            pcbc_pkg::S_WALK: begin
                // last clock pass from the hand; the victim is the first at one or less
                rd_addr = r_wa;
                if (r_cnt != CW'(SLOTS)) begin
                    n_cnt  = r_cnt + 1'b1;
                    n_pv   = 1'b1;
                    n_pidx = r_wa;
                    n_wa   = f_next(r_wa);
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    if (fl.unpinned) begin
                        if (fl.ref_le1) begin
                            we        = 1'b1;
                            tag_we    = 1'b1;
                            wdata     = meta_claim;
                            n_hand    = f_next(r_pidx);
                            n_rs_slot = pcbc_pkg::SLOT_W'(r_pidx);
                            n_rs_code = pcbc_pkg::C_EVICTED;
                            n_rs_ev   = tag_rd;
                            n_rs_evv  = 1'b1;
                            n_state   = pcbc_pkg::S_EMIT;
                        end else begin
                            we    = 1'b1;
                            wdata = {m_status, m_pin, ref_dec};
                        end
                    end
                end else if (r_cnt == CW'(SLOTS)) begin
                    n_rs_slot = '0;
                    n_rs_code = pcbc_pkg::C_NO_VICTIM;
                    n_rs_ev   = '0;
                    n_rs_evv  = 1'b0;
                    n_state   = pcbc_pkg::S_EMIT;
                end
            end
            pcbc_pkg::S_EMIT: begin
                if (!r_o_valid || o_out.ready) begin
                    load_out = 1'b1;
                    n_state  = pcbc_pkg::S_IDLE;
                end
            end
            default: n_state = pcbc_pkg::S_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= CW'(SLOTS))
        else $error("free slot count above slot count");

    a_hand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_hand) < SLOTS)
        else $error("clock hand out of range");

    a_evict_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.evicted_valid ==
                         (o_out.result_code == pcbc_pkg::C_EVICTED)))
        else $error("evicted_valid disagrees with result code");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("new word taken while a command is in work");
`endif

endmodule
`default_nettype wire

### design/pcbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pcbc_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### design/pcbc_slot_unit.sv
// Shared slot unit: decodes one slot word and forms its counter updates.
`default_nettype none
module pcbc_slot_unit #(
    parameter int PIN_BITS = pcbc_pkg::PIN_BITS_DEF,
    parameter int REF_BITS = pcbc_pkg::REF_BITS_DEF
) (
    input  wire logic [1:0]              i_status,
    input  wire logic [PIN_BITS-1:0]     i_pin,
    input  wire logic [REF_BITS-1:0]     i_ref,
    input  wire logic [pcbc_pkg::ID_W-1:0] i_tag,
    input  wire logic [pcbc_pkg::ID_W-1:0] i_id,
    input  wire logic [REF_BITS-1:0]     i_k,
    input  wire logic [REF_BITS-1:0]     i_m,
    output pcbc_pkg::t_slot_flags        o_flags,
    output logic      [PIN_BITS-1:0]     o_pin_inc,
    output logic      [PIN_BITS-1:0]     o_pin_dec,
    output logic      [REF_BITS-1:0]     o_ref_inc,
    output logic      [REF_BITS-1:0]     o_ref_sub,
    output logic      [REF_BITS-1:0]     o_ref_dec
);
    logic occ;

    assign occ = (i_status != pcbc_pkg::ST_FREE);

    always_comb begin
        o_flags.occupied = occ;
        o_flags.is_free  = !occ;
        o_flags.pending  = (i_status == pcbc_pkg::ST_PENDING);
        o_flags.loaded   = (i_status == pcbc_pkg::ST_LOADED);
        o_flags.unpinned = occ && (i_pin == '0);
        o_flags.tag_hit  = occ && (i_tag == i_id);
        o_flags.ref_le1  = (i_ref <= REF_BITS'(1));
        o_flags.ref_lt_m = (i_ref < i_m);
    end

    // saturating increments on a hit
    assign o_pin_inc = (i_pin == '1) ? i_pin : i_pin + 1'b1;
    assign o_ref_inc = (i_ref == '1) ? i_ref : i_ref + 1'b1;
    assign o_pin_dec = i_pin - 1'b1;
    assign o_ref_sub = i_ref - i_k;
    assign o_ref_dec = i_ref - 1'b1;
endmodule
`default_nettype wire
